// ===== design/zpg_pkg.sv =====
// Shared constants, register codes and widths for the zone plate generator.
package zpg_pkg;

    localparam int MAX_DIM_DEFAULT   = 4096;
    localparam int OUT_FRAC_DEFAULT  = 14;

    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;
    localparam int SAMPLE_W = 16;
    localparam int R2_W     = 25;
    localparam int MOD_W    = 14;
    localparam int FOLD_W   = 12;
    localparam int NUM_W    = 45;
    localparam int ANGLE_W  = 32;
    localparam int SQ_W     = 33;
    localparam int Y_W      = 32;
    localparam int TERMS    = 6;

    localparam logic [32:0] PI_Q31  = 33'd6746518852;
    localparam logic [32:0] ONE_Q31 = 33'h0_8000_0000;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // Taylor denominators, innermost term first.
    function automatic int series_denom(input int idx);
        int d;
        d = 12;
        case (idx)
            0: d = 182;
            1: d = 132;
            2: d = 90;
            3: d = 56;
            4: d = 30;
            default: d = 12;
        endcase
        return d;
    endfunction

endpackage

// ===== design/zpg_div_cell.sv =====
// One restoring division cell: takes one numerator bit per cycle while en is high.
module zpg_div_cell #(
    parameter int DW = 14,
    parameter int NW = 25,
    parameter int QW = 1,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [DW-1:0] divisor,
    input  logic          valid_in,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] num_in,
    input  logic [QW-1:0] quo_in,
    input  logic [SW-1:0] side_in,
    output logic          valid_out,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] num_out,
    output logic [QW-1:0] quo_out,
    output logic [SW-1:0] side_out
);

    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] num_reg;
    logic [QW-1:0] quo_reg;
    logic [SW-1:0] side_reg;

    always_comb
    begin
        trial    = {rem_in, num_in[NW-1]};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_in << 1;
            quo_reg  <= (quo_in << 1) | QW'(ge);
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign num_out   = num_reg;
    assign quo_out   = quo_reg;
    assign side_out  = side_reg;

endmodule

// ===== design/zpg_series_cell.sv =====
// One series term: y' = ONE - ((x*y) >> 31) / D, over three stages.
module zpg_series_cell
    import zpg_pkg::*;
#(
    parameter int D = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  logic [SQ_W-1:0] x_in,
    input  logic [Y_W-1:0]  y_in,
    input  logic            neg_in,
    output logic            valid_out,
    output logic [SQ_W-1:0] x_out,
    output logic [Y_W-1:0]  y_out,
    output logic            neg_out
);

    localparam int K = 33;
    localparam logic [30:0] RECIP = 31'((64'd1 << K) / D);

    logic [2:0]      valid_reg;
    logic [SQ_W-1:0] xa_reg, xb_reg, xc_reg;
    logic [2:0]      neg_reg;
    logic [32:0]     va_reg, vb_reg;
    logic [30:0]     est_reg;
    logic [Y_W-1:0]  y_reg;

    logic [64:0]     prod_a;
    logic [63:0]     prod_b;
    logic [30:0]     est_next;
    logic [33:0]     chk;
    logic [30:0]     quot;
    logic [Y_W-1:0]  y_next;

    always_comb
    begin
        prod_a   = x_in * y_in;
        prod_b   = va_reg * RECIP;
        est_next = prod_b[K+30:K];
        // The reciprocal estimate is low by at most one.
        chk      = {1'b0, vb_reg} - 34'(est_reg * 34'(D));
        quot     = (chk >= 34'(D)) ? est_reg + 31'd1 : est_reg;
        y_next   = Y_W'(ONE_Q31 - 33'(quot));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg  <= prod_a[63:31];
            xa_reg  <= x_in;
            vb_reg  <= va_reg;
            xb_reg  <= xa_reg;
            est_reg <= est_next;
            xc_reg  <= xb_reg;
            y_reg   <= y_next;
            neg_reg <= {neg_reg[1:0], neg_in};
        end
    end

    assign valid_out = valid_reg[2];
    assign x_out     = xc_reg;
    assign y_out     = y_reg;
    assign neg_out   = neg_reg[2];

endmodule

// ===== design/zone_plate_pixel_generator.sv =====
// Top level of the zone plate pixel generator: front end, cell chains and output buffer.
// Throughput: one pixel per clock unless the pipeline holds (output buffer full and not
// being read); the depth is set by the two one-bit-per-cell division chains (25 cells
// for the phase modulo, 32 for the angle) and six series cells.
// A two-entry output buffer keeps requests flowing while a result waits to be taken.
// Reset (rst_n low, asynchronous) empties the pipeline and sets both dimensions to 256.
module zone_plate_pixel_generator
    import zpg_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEFAULT,
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [COORD_W-1:0]         pixel_x,
    input  logic [COORD_W-1:0]         pixel_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample
);

    // ---------------------------------------------------------------
    // Configuration registers. Writes are masked to 13 bits, saturated
    // at MAX_DIM, and a zero width is taken as one.
    // ---------------------------------------------------------------
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             cfg_write;
    logic [DIM_W-1:0] wdata_clamped;
    reg_index_t       cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        wdata_clamped = pwdata[DIM_W-1:0];
        if (32'(wdata_clamped) > 32'(MAX_DIM))
        begin
            wdata_clamped = DIM_W'(MAX_DIM);
        end
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = (wdata_clamped == '0) ? DIM_W'(1) : wdata_clamped;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = wdata_clamped;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline advance. The whole chain moves together; it holds only
    // when the output buffer is full and nothing is being taken from it.
    // ---------------------------------------------------------------
    logic [1:0] count_reg, count_next;
    logic       en;

    assign en       = (count_reg != 2'd2) || out_ready;
    assign in_ready = en;

    // Front end: distance from the centre, squares, and their sum.
    logic [COORD_W-1:0] cx, cy;
    logic [COORD_W-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic [23:0]        dxsq_reg, dysq_reg;
    logic [R2_W-1:0]    r2_reg;
    logic [2:0]         fe_valid_reg;

    always_comb
    begin
        cx      = COORD_W'(width_reg >> 1);
        cy      = COORD_W'(height_reg >> 1);
        dx_next = (pixel_x >= cx) ? pixel_x - cx : cx - pixel_x;
        dy_next = (pixel_y >= cy) ? pixel_y - cy : cy - pixel_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= '0;
        end
        else if (en)
        begin
            fe_valid_reg <= {fe_valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            dxsq_reg <= dx_reg * dx_reg;
            dysq_reg <= dy_reg * dy_reg;
            r2_reg   <= R2_W'(dxsq_reg) + R2_W'(dysq_reg);
        end
    end

    // ---------------------------------------------------------------
    // Phase reduction: r2 mod 2W through a chain of division cells,
    // one bit of r2 per cell.
    // ---------------------------------------------------------------
    logic [MOD_W-1:0] two_w;
    logic             mv   [0:R2_W];
    logic [MOD_W-1:0] mrem [0:R2_W];
    logic [R2_W-1:0]  mnum [0:R2_W];
    logic             mquo [0:R2_W];
    logic             mside[0:R2_W];

    assign two_w    = {width_reg, 1'b0};
    assign mv[0]    = fe_valid_reg[2];
    assign mrem[0]  = '0;
    assign mnum[0]  = r2_reg;
    assign mquo[0]  = 1'b0;
    assign mside[0] = 1'b0;

    for (genvar i = 0; i < R2_W; i++)
    begin : g_mod
        zpg_div_cell #(
            .DW (MOD_W),
            .NW (R2_W),
            .QW (1),
            .SW (1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (two_w),
            .valid_in  (mv[i]),
            .rem_in    (mrem[i]),
            .num_in    (mnum[i]),
            .quo_in    (mquo[i]),
            .side_in   (mside[i]),
            .valid_out (mv[i+1]),
            .rem_out   (mrem[i+1]),
            .num_out   (mnum[i+1]),
            .quo_out   (mquo[i+1]),
            .side_out  (mside[i+1])
        );
    end

    // Fold the phase onto the first quadrant and note the sign.
    logic [MOD_W-1:0]  p, q1;
    logic              neg_next, fold_neg_reg, fold_valid_reg;
    logic [FOLD_W-1:0] q_next, q_reg;

    always_comb
    begin
        p        = mrem[R2_W];
        q1       = (p <= MOD_W'(width_reg)) ? p : two_w - p;
        neg_next = ({q1, 1'b0} > {2'b0, width_reg});
        q_next   = neg_next ? FOLD_W'(MOD_W'(width_reg) - q1) : FOLD_W'(q1);
    end

    // Angle numerator q*pi + W/2, ready for division by W.
    logic [NUM_W-1:0] numer_reg;
    logic             mul_neg_reg, mul_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
            mul_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            fold_valid_reg <= mv[R2_W];
            mul_valid_reg  <= fold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg        <= q_next;
            fold_neg_reg <= neg_next;
            numer_reg    <= NUM_W'(q_reg * PI_Q31) + NUM_W'(width_reg >> 1);
            mul_neg_reg  <= fold_neg_reg;
        end
    end

    // ---------------------------------------------------------------
    // Angle division by W: the quotient is below 2^32, so the top bits
    // of the numerator start as the remainder and 32 cells follow.
    // ---------------------------------------------------------------
    logic               dv   [0:ANGLE_W];
    logic [DIM_W-1:0]   drem [0:ANGLE_W];
    logic [ANGLE_W-1:0] dnum [0:ANGLE_W];
    logic [ANGLE_W-1:0] dquo [0:ANGLE_W];
    logic               dside[0:ANGLE_W];

    assign dv[0]    = mul_valid_reg;
    assign drem[0]  = numer_reg[NUM_W-1:ANGLE_W];
    assign dnum[0]  = numer_reg[ANGLE_W-1:0];
    assign dquo[0]  = '0;
    assign dside[0] = mul_neg_reg;

    for (genvar i = 0; i < ANGLE_W; i++)
    begin : g_div
        zpg_div_cell #(
            .DW (DIM_W),
            .NW (ANGLE_W),
            .QW (ANGLE_W),
            .SW (1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (width_reg),
            .valid_in  (dv[i]),
            .rem_in    (drem[i]),
            .num_in    (dnum[i]),
            .quo_in    (dquo[i]),
            .side_in   (dside[i]),
            .valid_out (dv[i+1]),
            .rem_out   (drem[i+1]),
            .num_out   (dnum[i+1]),
            .quo_out   (dquo[i+1]),
            .side_out  (dside[i+1])
        );
    end

    // Square of the angle in Q31.
    logic [63:0]     asq;
    logic [SQ_W-1:0] x_reg;
    logic            sq_neg_reg, sq_valid_reg;

    assign asq = dquo[ANGLE_W] * dquo[ANGLE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= dv[ANGLE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= asq[63:31];
            sq_neg_reg <= dside[ANGLE_W];
        end
    end

    // ---------------------------------------------------------------
    // Horner evaluation of the cosine series, one cell per term.
    // ---------------------------------------------------------------
    logic            sv [0:TERMS];
    logic [SQ_W-1:0] sx [0:TERMS];
    logic [Y_W-1:0]  sy [0:TERMS];
    logic            sn [0:TERMS];

    assign sv[0] = sq_valid_reg;
    assign sx[0] = x_reg;
    assign sy[0] = Y_W'(ONE_Q31);
    assign sn[0] = sq_neg_reg;

    for (genvar i = 0; i < TERMS; i++)
    begin : g_series
        zpg_series_cell #(
            .D (series_denom(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sv[i]),
            .x_in      (sx[i]),
            .y_in      (sy[i]),
            .neg_in    (sn[i]),
            .valid_out (sv[i+1]),
            .x_out     (sx[i+1]),
            .y_out     (sy[i+1]),
            .neg_out   (sn[i+1])
        );
    end

    // Last half-term, rounding to the output format and the sign.
    logic [64:0]         fprod;
    logic [32:0]         fv_reg;
    logic                fin_neg_reg, fin_valid_reg;
    logic [32:0]         h;
    logic [32:0]         c;
    logic [33:0]         rounded;
    logic [SAMPLE_W-1:0] mag, sample_next;

    assign fprod = sx[TERMS] * sy[TERMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= sv[TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fv_reg      <= fprod[63:31];
            fin_neg_reg <= sn[TERMS];
        end
    end

    always_comb
    begin
        h           = fv_reg >> 1;
        c           = (h >= ONE_Q31) ? '0 : ONE_Q31 - h;
        rounded     = ({1'b0, c} + (34'd1 << (30 - OUT_FRAC_BITS))) >> (31 - OUT_FRAC_BITS);
        mag         = rounded[SAMPLE_W-1:0];
        sample_next = fin_neg_reg ? SAMPLE_W'(-mag) : mag;
    end

    // ---------------------------------------------------------------
    // Two-entry output buffer, so that the chain keeps moving while one
    // result waits to be taken.
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0] buf_reg [0:1];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic                push, pop;

    assign push = en && fin_valid_reg;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= sample_next;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign sample    = buf_reg[rd_ptr_reg];

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !out_ready) |-> !in_ready)
        else $error("request taken while output buffer full");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("result lost on entry to output buffer");

    a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg != '0)
        else $error("image width register holds zero");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the zone plate pixel generator.
module tb
    import zpg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_req_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic out_valid;
    logic out_ready;
    logic signed [SAMPLE_W-1:0] sample;

    // Requests waiting to be offered, and samples predicted for accepted requests.
    pixel_req_t pixel_queue[$];
    logic [SAMPLE_W-1:0] sample_queue[$];

    // The predictor's own copy of the two dimension registers.
    int unsigned cur_width;
    int unsigned cur_height;

    int mismatches;
    int accepted;
    int cycles;
    logic rx_hold;

    zone_plate_pixel_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .out_valid(out_valid), .out_ready(out_ready), .sample(sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A register value is masked to 13 bits and saturated; a zero width reads as one.
    function automatic int unsigned clamp_dimension(input logic [31:0] v, input bit is_width);
        int unsigned d;
        d = v[DIM_W-1:0];
        if (d > MAX_DIM_DEFAULT)
            d = MAX_DIM_DEFAULT;
        if (is_width && d == 0)
            d = 1;
        return d;
    endfunction

    // Cosine of the quadratic phase, evaluated in Q31 exactly as the hardware does.
    function automatic logic [SAMPLE_W-1:0] zone_sample(input logic [COORD_W-1:0] px,
                                                         input logic [COORD_W-1:0] py,
                                                         input int unsigned w,
                                                         input int unsigned h);
        longint unsigned one_q31;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned phase;
        longint unsigned fold;
        longint unsigned angle;
        longint unsigned sq;
        longint unsigned y;
        longint unsigned half;
        longint unsigned c;
        longint unsigned s;
        longint unsigned denoms[6];
        bit neg;
        one_q31 = 64'd1 << 31;
        denoms = '{182, 132, 90, 56, 30, 12};
        dx = (px >= w / 2) ? px - w / 2 : w / 2 - px;
        dy = (py >= h / 2) ? py - h / 2 : h / 2 - py;
        phase = (dx * dx + dy * dy) % (2 * w);
        fold = (phase <= w) ? phase : 2 * w - phase;
        neg = 1'b0;
        if (2 * fold > w)
        begin
            neg = 1'b1;
            fold = w - fold;
        end
        angle = (fold * 64'd6746518852 + (w >> 1)) / w;
        sq = (angle * angle) >> 31;
        y = one_q31;
        for (int i = 0; i < 6; i++)
            y = one_q31 - ((sq * y) >> 31) / denoms[i];
        half = ((sq * y) >> 31) / 2;
        c = (half >= one_q31) ? 0 : one_q31 - half;
        s = (c + (64'd1 << (30 - OUT_FRAC_DEFAULT))) >> (31 - OUT_FRAC_DEFAULT);
        if (neg)
            s = 64'd0 - s;
        return s[SAMPLE_W-1:0];
    endfunction

    // Two-phase register write; the register takes the value at the access edge.
    task automatic write_dimension(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cur_width = clamp_dimension(value, 1'b1);
        else
            cur_height = clamp_dimension(value, 1'b0);
    endtask

    // Bursty sender: a burst of random length, then a random gap. Valid holds until taken.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        pixel_req_t req;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            pixel_x    <= '0;
            pixel_y    <= '0;
            burst_left = 8;
            gap_left   = 0;
        end
        else
        begin
            next_valid = in_valid && !in_ready;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pixel_queue.size() > 0)
                begin
                    req = pixel_queue.pop_front();
                    pixel_x <= req.x;
                    pixel_y <= req.y;
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // Receiver stall pattern: its mode is redrawn at random periodically, from never stalling
    // to stalling often. The long hold-off overrides it.
    int rx_mode;
    always @(posedge clk or negedge rst_n)
    begin
        logic ready_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode = 0;
        end
        else
        begin
            if (cycles % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: ready_next = 1'b1;
                1: ready_next = ($urandom_range(0, 1) == 1);
                2: ready_next = ($urandom_range(0, 7) != 0);
                default: ready_next = ($urandom_range(0, 7) == 0);
            endcase
            out_ready <= ready_next && !rx_hold;
        end
    end

    // Long receiver hold-off while the sender keeps offering, so the pipeline fills
    // and in_ready must drop.
    initial
    begin
        rx_hold = 1'b0;
        wait (accepted >= 300);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor: predict on every accepted request, check every accepted sample.
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sample_queue.push_back(zone_sample(pixel_x, pixel_y, cur_width, cur_height));
                accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (sample_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sample %0d with nothing pending", sample);
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (sample !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample mismatch: expected %0d, got %0d",
                                     $signed(want), sample);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_pixel(input int unsigned x, input int unsigned y);
        pixel_req_t req;
        req.x = x[COORD_W-1:0];
        req.y = y[COORD_W-1:0];
        pixel_queue.push_back(req);
    endtask

    // Wait until nothing is queued or offered and every predicted sample has come
    // back; the check is made at the falling edge, once the driver has settled.
    task automatic drain();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || sample_queue.size() != 0);
    endtask

    int unsigned widths[8];
    int unsigned heights[8];

    initial
    begin
        int unsigned span_x;
        int unsigned span_y;
        cur_width = 256;
        cur_height = 256;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        // The first phase runs on the reset dimensions; the others cover a zero width,
        // the largest size, values that saturate and lopsided shapes.
        widths  = '{256, 0, 4096, 8191, 5000, 1, 3, 0};
        heights = '{256, 0, 4096, 8191, 3, 4096, 640, 0};
        widths[7]  = $urandom_range(2, 4096);
        heights[7] = $urandom_range(1, 4096);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                write_dimension(REG_IMAGE_WIDTH, widths[ph]);
                write_dimension(REG_IMAGE_HEIGHT, heights[ph]);
            end
            // Corners, the centre and its neighbours.
            if (ph < 3)
            begin
                add_pixel(0, 0);
                add_pixel(4095, 4095);
                add_pixel(0, 4095);
                add_pixel(4095, 0);
                add_pixel(cur_width / 2, cur_height / 2);
                add_pixel(cur_width / 2 + 1, cur_height / 2);
                add_pixel(cur_width / 2, cur_height / 2 + 1);
            end
            span_x = (cur_width > 4095) ? 4095 : cur_width;
            span_y = (cur_height > 4095) ? 4095 : cur_height;
            for (int i = 0; i < 220; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                else
                    add_pixel($urandom_range(0, span_x), $urandom_range(0, span_y));
            end
            // The sender stops here until every predicted sample has come back.
            drain();
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/zpg_pkg.sv
design/zpg_div_cell.sv
design/zpg_series_cell.sv
design/zone_plate_pixel_generator.sv
bench/tb.sv
